[hw/rtl/tshn_pkg.sv]
// package for the two-stack history navigator
// holds op and status codes, controller states and the command/status structs
`timescale 1ns / 1ps

package tshn_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 128;
  localparam int unsigned PAGE_ID_BITS_DEF  = 16;
  localparam int unsigned FIELD_PAGE_W      = 16;
  localparam int unsigned COUNT_W           = 8;

  typedef enum logic [1:0] {
    OP_VISIT   = 2'd0,
    OP_BACK    = 2'd1,
    OP_FORWARD = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_BACK = 2'd1,
    STATUS_NO_FWD  = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } ctrl_stat_t;

endpackage

[hw/rtl/two_stack_history_navigator_core.sv]
// an accepted request is latched with both stack tops into registers, and the exec state
//   writes its result to the output register, waiting there while the output stalls;
//   a new request is taken only after the previous one has committed
// reset: asynchronous active low; depth counters and present page go to zero, output valid
//   clears, and the stack memories keep whatever they hold (no clearing pass)
// top level of the navigator; depends on tshn_pkg, tshn_ctrl and tshn_datapath
`timescale 1ns / 1ps

module two_stack_history_navigator_core
  import tshn_pkg::*;
#(
  parameter int unsigned HistoryDepth = HISTORY_DEPTH_DEF,
  parameter int unsigned PageIdBits   = PAGE_ID_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // home page write
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [FIELD_PAGE_W-1:0] cfg_data_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              operation_i,
  input  logic [FIELD_PAGE_W-1:0] page_id_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [FIELD_PAGE_W-1:0] current_page_o,
  output logic [1:0]              status_o,
  output logic [COUNT_W-1:0]      back_count_o,
  output logic [COUNT_W-1:0]      forward_count_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  logic       cfg_we;

  // the home page write is always accepted; it only has effect before the
  // first request, when it sets the present page
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // controller: idle takes a request, exec commits once the output is free
  tshn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: both stacks, their depths, present page and the result register
  tshn_datapath #(
    .HistoryDepth (HistoryDepth),
    .PageIdBits   (PageIdBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .page_id_i       (page_id_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .current_page_o  (current_page_o),
    .status_o        (status_o),
    .back_count_o    (back_count_o),
    .forward_count_o (forward_count_o)
  );

endmodule

[hw/rtl/tshn_ctrl.sv]
// controller state machine of the history navigator
// depends on tshn_pkg for states and command/status structs
`timescale 1ns / 1ps

module tshn_ctrl
  import tshn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the output register can take the result
        if (!stat_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/tshn_datapath.sv]
// datapath of the history navigator: stack memories, depth counters,
// present page and output register; depends on tshn_pkg
`timescale 1ns / 1ps

module tshn_datapath
  import tshn_pkg::*;
#(
  parameter int unsigned HistoryDepth = HISTORY_DEPTH_DEF,
  parameter int unsigned PageIdBits   = PAGE_ID_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output ctrl_stat_t              stat_o,
  input  logic                    cfg_we_i,
  input  logic [FIELD_PAGE_W-1:0] cfg_data_i,
  input  logic [1:0]              operation_i,
  input  logic [FIELD_PAGE_W-1:0] page_id_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [FIELD_PAGE_W-1:0] current_page_o,
  output logic [1:0]              status_o,
  output logic [COUNT_W-1:0]      back_count_o,
  output logic [COUNT_W-1:0]      forward_count_o
);

  localparam int unsigned AddrBits  = (HistoryDepth > 1) ? $clog2(HistoryDepth) : 1;
  localparam int unsigned DepthBits = $clog2(HistoryDepth + 1);
  localparam logic [DepthBits-1:0] DepthFull = DepthBits'(HistoryDepth);

  logic [PageIdBits-1:0] back_mem [HistoryDepth];
  logic [PageIdBits-1:0] fwd_mem  [HistoryDepth];

  op_e                   op_q;
  logic [PageIdBits-1:0] page_q;
  logic [PageIdBits-1:0] back_rd_q, fwd_rd_q;
  logic [PageIdBits-1:0] present_q, present_d;
  logic [DepthBits-1:0]  bd_q, bd_d, fd_q, fd_d;
  logic                  fresh_q;
  logic                  out_valid_q;
  logic [FIELD_PAGE_W-1:0] out_page_q;
  status_e               out_status_q, status_d;
  logic [COUNT_W-1:0]    out_bc_q, out_fc_q;

  logic                  back_we, fwd_we;
  logic [DepthBits-1:0]  bd_dec, fd_dec;
  logic [PageIdBits+FIELD_PAGE_W-1:0] in_page_ext, cfg_page_ext, out_page_ext;
  logic [DepthBits+COUNT_W-1:0]       bc_ext, fc_ext;

  // page id width conversion: zero padded when widening, truncated to the low bits when narrowing
  assign in_page_ext  = {{PageIdBits{1'b0}}, page_id_i};
  assign cfg_page_ext = {{PageIdBits{1'b0}}, cfg_data_i};
  assign out_page_ext = {{FIELD_PAGE_W{1'b0}}, present_d};
  assign bc_ext       = {{COUNT_W{1'b0}}, bd_d};
  assign fc_ext       = {{COUNT_W{1'b0}}, fd_d};

  assign bd_dec = bd_q - 1'b1;
  assign fd_dec = fd_q - 1'b1;

  // latch the request and read both stack tops
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_e'(operation_i);
      page_q   <= in_page_ext[PageIdBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[bd_q[AddrBits-1:0]] <= present_q;
    end
    if (cmd_i.accept) begin
      back_rd_q <= back_mem[bd_dec[AddrBits-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[fd_q[AddrBits-1:0]] <= present_q;
    end
    if (cmd_i.accept) begin
      fwd_rd_q <= fwd_mem[fd_dec[AddrBits-1:0]];
    end
  end

  // next state of the navigator for the latched request
  always_comb begin
    bd_d      = bd_q;
    fd_d      = fd_q;
    present_d = present_q;
    status_d  = STATUS_OK;
    back_we   = 1'b0;
    fwd_we    = 1'b0;
    unique case (op_q)
      OP_VISIT: begin
        if (bd_q == DepthFull) begin
          status_d = STATUS_FULL;
        end else begin
          back_we = cmd_i.commit;
          bd_d    = bd_q + 1'b1;
        end
        fd_d      = '0;
        present_d = page_q;
      end
      OP_BACK: begin
        if (bd_q == '0) begin
          status_d = STATUS_NO_BACK;
        end else begin
          if (fd_q == DepthFull) begin
            status_d = STATUS_FULL;
          end else begin
            fwd_we = cmd_i.commit;
            fd_d   = fd_q + 1'b1;
          end
          bd_d      = bd_dec;
          present_d = back_rd_q;
        end
      end
      OP_FORWARD: begin
        if (fd_q == '0) begin
          status_d = STATUS_NO_FWD;
        end else begin
          if (bd_q == DepthFull) begin
            status_d = STATUS_FULL;
          end else begin
            back_we = cmd_i.commit;
            bd_d    = bd_q + 1'b1;
          end
          fd_d      = fd_dec;
          present_d = fwd_rd_q;
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bd_q        <= '0;
      fd_q        <= '0;
      present_q   <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        fresh_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        bd_q      <= bd_d;
        fd_q      <= fd_d;
        present_q <= present_d;
      end else if (cfg_we_i && fresh_q) begin
        present_q <= cfg_page_ext[PageIdBits-1:0];
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_page_q   <= out_page_ext[FIELD_PAGE_W-1:0];
      out_status_q <= status_d;
      out_bc_q     <= bc_ext[COUNT_W-1:0];
      out_fc_q     <= fc_ext[COUNT_W-1:0];
    end
  end

  assign stat_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign current_page_o     = out_page_q;
  assign status_o           = out_status_q;
  assign back_count_o       = out_bc_q;
  assign forward_count_o    = out_fc_q;

endmodule

[hw/rtl/tshn_checker.sv]
// port level checks for the history navigator, bound to the top level
// depends on tshn_pkg for status codes
`timescale 1ns / 1ps

module tshn_checker
  import tshn_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [FIELD_PAGE_W-1:0] current_page_o,
  input logic [1:0]              status_o,
  input logic [COUNT_W-1:0]      back_count_o,
  input logic [COUNT_W-1:0]      forward_count_o
);

  // one request in flight: the input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in flight");

  // a new result only appears at the end of a request's execution
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(current_page_o)))
    else $error("stalled result changed");

  // refused moves report an empty source stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_NO_FWD) |-> (forward_count_o == '0))
    else $error("no forward history reported with a nonempty forward stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_NO_BACK) |-> (back_count_o == '0))
    else $error("no back history reported with a nonempty back stack");

endmodule

bind two_stack_history_navigator_core tshn_checker u_tshn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .current_page_o  (current_page_o),
  .status_o        (status_o),
  .back_count_o    (back_count_o),
  .forward_count_o (forward_count_o)
);
